// ===== rtl/rcpg_pkg.sv =====
// Shared widths, register indexes, sequencer states and status types of the rainbow generator.
`timescale 1ns / 1ps

package rcpg_pkg;

    localparam int IDX_W     = 10;
    localparam int SPREAD_W  = 16;
    localparam int STEP_W    = 9;
    localparam int COLOUR_W  = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = SPREAD_W;

    localparam int MAX_PIXELS = 1024;

    // dividend is index * 256, i.e. index followed by eight zero bits
    localparam int FRAC_BITS = 8;
    localparam int DIV_STEPS = IDX_W + FRAC_BITS;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [SPREAD_W-1:0] HUE_SPREAD_RESET = 16'd90;
    localparam logic [STEP_W-1:0]   FRAME_STEP_RESET = 9'd14;

    localparam logic [CFG_IDX_W-1:0] REG_HUE_SPREAD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_STEP = 2'd1;

    localparam logic [COLOUR_W-1:0] SEG_ONE = 8'd85;
    localparam logic [COLOUR_W-1:0] SEG_TWO = 8'd170;
    localparam logic [COLOUR_W-1:0] FULL    = 8'd255;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_WAIT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ===== rtl/rcpg_if.sv =====
// Valid/ready channel interfaces for pixel requests and pixel colours.
`timescale 1ns / 1ps

interface rcpg_pix_in_if;
    import rcpg_pkg::*;

    logic                valid;
    logic                ready;
    logic [IDX_W-1:0]    pixel_index;
    logic                frame_end;

    modport source (output valid, output pixel_index, output frame_end, input ready);
    modport sink   (input valid, input pixel_index, input frame_end, output ready);
endinterface

interface rcpg_pix_out_if;
    import rcpg_pkg::*;

    logic                valid;
    logic                ready;
    logic [COLOUR_W-1:0] red;
    logic [COLOUR_W-1:0] green;
    logic [COLOUR_W-1:0] blue;
    logic                last_of_frame;

    modport source (output valid, output red, output green, output blue,
                    output last_of_frame, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input last_of_frame, output ready);
endinterface

// ===== rtl/rcpg_div.sv =====
// Restoring divider, one quotient bit per cycle, keeping the low quotient byte.
`timescale 1ns / 1ps

module rcpg_div
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [rcpg_pkg::IDX_W-1:0]     dividend,
    input  logic [rcpg_pkg::SPREAD_W-1:0]  divisor,
    output logic [rcpg_pkg::COLOUR_W-1:0]  quotient,
    output rcpg_pkg::div_status_t          status
);
    import rcpg_pkg::*;

    logic [CNT_W-1:0]    cnt_reg,  cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [SPREAD_W-1:0] rem_reg,  rem_next;
    logic [IDX_W-1:0]    dvd_reg,  dvd_next;
    logic [SPREAD_W-1:0] dvs_reg,  dvs_next;
    logic [COLOUR_W-1:0] q_reg,    q_next;

    logic [SPREAD_W:0]   rem_sh;
    logic [SPREAD_W:0]   diff;
    logic                ge;

    assign rem_sh = {rem_reg, dvd_reg[IDX_W-1]};
    assign diff   = rem_sh - {1'b0, dvs_reg};
    assign ge     = (rem_sh >= {1'b0, dvs_reg});

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        q_next    = q_reg;
        if (start && !busy_reg)
        begin
            cnt_next  = '0;
            busy_next = 1'b1;
            rem_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so it fits the low bits
            rem_next = ge ? diff[SPREAD_W-1:0] : rem_sh[SPREAD_W-1:0];
            dvd_next = {dvd_reg[IDX_W-2:0], 1'b0};
            q_next   = {q_reg[COLOUR_W-2:0], ge};
            if (cnt_reg == CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        q_reg   <= q_next;
    end

    assign quotient    = q_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== rtl/rainbow_cycle_pixel_generator.sv =====
// Top level: pixel index to rainbow colour with a per-frame hue offset.
//
//  channel    dir  handshake      payload
//  pixel_in   in   valid/ready    pixel_index[9:0], frame_end
//  pixel_out  out  valid/ready    red[7:0], green[7:0], blue[7:0], last_of_frame
//  cfg        in   cfg_we only    cfg_index[1:0], cfg_data[15:0]
//
// An item is accepted, passed through the bit-serial divider (one quotient bit a
// cycle through the shared subtractor), then loaded into the output register.
// pixel_in is ready only while the sequencer is idle; the output register holds
// a finished colour so the next index can be taken while it waits.
// A stalled output holds the sequencer in its wait state until the beat goes.
// Reset: hue_spread 90, frame_step 14, frame offset 0, no beat pending.
`timescale 1ns / 1ps

module rainbow_cycle_pixel_generator
(
    input  logic                            clk,
    input  logic                            rst_n,
    rcpg_pix_in_if.sink                     pixel_in,
    rcpg_pix_out_if.source                  pixel_out,
    input  logic                            cfg_we,
    input  logic [rcpg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rcpg_pkg::CFG_W-1:0]      cfg_data
);
    import rcpg_pkg::*;

    state_t              state_reg, state_next;
    logic [SPREAD_W-1:0] spread_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [COLOUR_W-1:0] offset_reg, offset_next;
    logic                last_reg;
    logic                out_valid_reg, out_valid_next;
    logic [COLOUR_W-1:0] red_reg, green_reg, blue_reg;
    logic                olast_reg;

    logic                accept;
    logic                load;
    logic                slot_free;
    logic [IDX_W-1:0]    idx_sat;
    logic [COLOUR_W-1:0] quotient;
    div_status_t         div_st;
    logic [COLOUR_W-1:0] hue, p, p3;
    logic [COLOUR_W-1:0] r_c, g_c, b_c;
    logic [STEP_W:0]     offset_sum;

    assign accept    = pixel_in.valid && pixel_in.ready;
    assign slot_free = !out_valid_reg || pixel_out.ready;

    // saturate to the strip length
    assign idx_sat = ({1'b0, pixel_in.pixel_index} >= (IDX_W+1)'(MAX_PIXELS))
                   ? IDX_W'(MAX_PIXELS - 1) : pixel_in.pixel_index;

    rcpg_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .dividend (idx_sat),
        .divisor  (spread_reg),
        .quotient (quotient),
        .status   (div_st)
    );

    // colour wheel
    assign hue = quotient + offset_reg;

    always_comb
    begin
        if (hue < SEG_ONE)
        begin
            p = hue;
        end
        else if (hue < SEG_TWO)
        begin
            p = hue - SEG_ONE;
        end
        else
        begin
            p = hue - SEG_TWO;
        end
        p3 = p + {p[COLOUR_W-2:0], 1'b0};
        if (hue < SEG_ONE)
        begin
            r_c = p3;
            g_c = FULL - p3;
            b_c = '0;
        end
        else if (hue < SEG_TWO)
        begin
            r_c = FULL - p3;
            g_c = '0;
            b_c = p3;
        end
        else
        begin
            r_c = '0;
            g_c = p3;
            b_c = FULL - p3;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        load       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_st.done)
                begin
                    if (slot_free)
                    begin
                        load       = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_WAIT;
                    end
                end
            end
            ST_WAIT:
            begin
                if (slot_free)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign pixel_in.ready = (state_reg == ST_IDLE) && !div_st.busy;

    // offset moves on once the frame's last colour is out of the datapath
    assign offset_sum = {2'b00, offset_reg} + {1'b0, step_reg};

    always_comb
    begin
        offset_next = offset_reg;
        if (load && last_reg)
        begin
            offset_next = (offset_sum >= (STEP_W+1)'(256)) ? '0 : offset_sum[COLOUR_W-1:0];
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pixel_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            spread_reg    <= HUE_SPREAD_RESET;
            step_reg      <= FRAME_STEP_RESET;
            offset_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            offset_reg    <= offset_next;
            out_valid_reg <= out_valid_next;
            // zero writes are dropped
            if (cfg_we && (cfg_index == REG_HUE_SPREAD) && (cfg_data != '0))
            begin
                spread_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == REG_FRAME_STEP) && (cfg_data[STEP_W-1:0] != '0))
            begin
                step_reg <= cfg_data[STEP_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            last_reg <= pixel_in.frame_end;
        end
        if (load)
        begin
            red_reg   <= r_c;
            green_reg <= g_c;
            blue_reg  <= b_c;
            olast_reg <= last_reg;
        end
    end

    assign pixel_out.valid         = out_valid_reg;
    assign pixel_out.red           = red_reg;
    assign pixel_out.green         = green_reg;
    assign pixel_out.blue          = blue_reg;
    assign pixel_out.last_of_frame = olast_reg;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the rainbow cycle pixel generator.
`timescale 1ns / 1ps

module tb;
    import rcpg_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 25;
    localparam int DRAIN_CYCLES   = 40;
    localparam int PHASE_ITEMS    = 190;
    localparam int REPORT_CAP     = 100;

    // indexes beyond the two registers; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [COLOUR_W-1:0] red;
        logic [COLOUR_W-1:0] green;
        logic [COLOUR_W-1:0] blue;
        logic                last_of_frame;
    } pixel_colour_t;

    class rainbow_scoreboard;
        logic [SPREAD_W-1:0] hue_spread;
        logic [STEP_W-1:0]   frame_step;
        logic [7:0]          frame_offset;
        pixel_colour_t       colours_due[$];
        int                  errors;

        function new();
            hue_spread   = HUE_SPREAD_RESET;
            frame_step   = FRAME_STEP_RESET;
            frame_offset = '0;
            errors       = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
            case (index)
                REG_HUE_SPREAD:
                    if (data != '0)
                        hue_spread = data;
                REG_FRAME_STEP:
                    if (data[STEP_W-1:0] != '0)
                        frame_step = data[STEP_W-1:0];
                default: ;
            endcase
        endfunction

        function pixel_colour_t wheel_colour(logic [7:0] hue);
            pixel_colour_t c;
            logic [7:0]    p;
            logic [7:0]    p3;
            c = '0;
            if (hue < SEG_ONE)
            begin
                p       = hue;
                p3      = 8'(p * 3);
                c.red   = p3;
                c.green = FULL - p3;
            end
            else if (hue < SEG_TWO)
            begin
                p      = hue - SEG_ONE;
                p3     = 8'(p * 3);
                c.red  = FULL - p3;
                c.blue = p3;
            end
            else
            begin
                p       = hue - SEG_TWO;
                p3      = 8'(p * 3);
                c.green = p3;
                c.blue  = FULL - p3;
            end
            return c;
        endfunction

        function void note_pixel(logic [IDX_W-1:0] index, logic frame_end);
            int unsigned   quotient;
            logic [7:0]    hue;
            logic [9:0]    next_offset;
            pixel_colour_t c;
            quotient = (int'(index) * 256) / int'(hue_spread);
            hue      = quotient[7:0] + frame_offset;
            c        = wheel_colour(hue);
            c.last_of_frame = frame_end;
            colours_due.push_back(c);
            if (frame_end)
            begin
                next_offset  = frame_offset + frame_step;
                frame_offset = (next_offset >= 10'd256) ? 8'd0 : next_offset[7:0];
            end
        endfunction

        function int pending();
            return colours_due.size();
        endfunction

        task report(string what, int got, int want);
            if (errors < REPORT_CAP)
                $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
            errors++;
        endtask

        task check_colour(logic [COLOUR_W-1:0] red, logic [COLOUR_W-1:0] green,
                          logic [COLOUR_W-1:0] blue, logic last_of_frame);
            pixel_colour_t want;
            if (colours_due.size() == 0)
            begin
                report("unexpected beat", 1, 0);
                return;
            end
            want = colours_due.pop_front();
            if (red !== want.red)
                report("red", red, want.red);
            if (green !== want.green)
                report("green", green, want.green);
            if (blue !== want.blue)
                report("blue", blue, want.blue);
            if (last_of_frame !== want.last_of_frame)
                report("last_of_frame", last_of_frame, want.last_of_frame);
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    rcpg_pix_in_if  pix_in();
    rcpg_pix_out_if pix_out();

    rainbow_scoreboard sb;
    int                gap_pct     = 0;
    int                stall_pct   = 0;
    int                quiet_cycles = 0;

    rainbow_cycle_pixel_generator dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel_in  (pix_in),
        .pixel_out (pix_out),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // sink side: random stall bursts, always ready when stall_pct is zero
    initial
    begin
        pix_out.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 99) < stall_pct)
            begin
                pix_out.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
            end
            pix_out.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pix_out.valid && pix_out.ready)
            sb.check_colour(pix_out.red, pix_out.green, pix_out.blue, pix_out.last_of_frame);
    end

    always @(posedge clk)
    begin
        if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // entered and left at a falling edge; valid stays up for a following beat
    task automatic send_pixel(input logic [IDX_W-1:0] index, input logic frame_end);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            pix_in.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        pix_in.valid       <= 1'b1;
        pix_in.pixel_index <= index;
        pix_in.frame_end   <= frame_end;
        do
            @(posedge clk);
        while (!pix_in.ready);
        sb.note_pixel(index, frame_end);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
        sb.write_reg(index, data);
    endtask

    // drop valid, let every colour come back, then give the sequencer time to go idle
    task automatic settle();
        pix_in.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // mostly whole frames of consecutive pixels, some loose pixels with random frame marks
    task automatic run_frames(input int n_items);
        int               sent;
        int               len;
        logic [IDX_W-1:0] start;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                len   = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 120)
                                                    : $urandom_range(1, 24);
                start = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom_range(0, 1023)) : '0;
                for (int k = 0; k < len; k++)
                    send_pixel(start + IDX_W'(k), k == len - 1);
            end
            else
            begin
                len = $urandom_range(1, 8);
                for (int k = 0; k < len; k++)
                    send_pixel(IDX_W'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
            end
            sent += len;
        end
    endtask

    initial
    begin
        sb                 = new();
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        pix_in.valid       = 1'b0;
        pix_in.pixel_index = '0;
        pix_in.frame_end   = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings, no frame end so the offset is still zero afterwards
        send_pixel(10'd0, 1'b0);
        send_pixel(10'd1023, 1'b0);
        send_pixel(10'd512, 1'b0);
        send_pixel(10'd45, 1'b0);

        // spread 256 makes the hue the low index byte plus offset: walk the segment edges
        settle();
        write_reg(REG_HUE_SPREAD, 16'd256);
        write_reg(REG_FRAME_STEP, 16'd85);
        send_pixel(10'd0, 1'b0);
        send_pixel(10'd84, 1'b0);
        send_pixel(10'd85, 1'b0);
        send_pixel(10'd169, 1'b0);
        send_pixel(10'd170, 1'b0);
        send_pixel(10'd255, 1'b1);
        send_pixel(10'd0, 1'b0);
        send_pixel(10'd170, 1'b1);
        send_pixel(10'd85, 1'b0);
        send_pixel(10'd86, 1'b1);
        send_pixel(10'd1, 1'b0);
        send_pixel(10'd1023, 1'b1);   // offset wraps back to zero here
        send_pixel(10'd1023, 1'b1);
        settle();
        write_reg(REG_FRAME_STEP, 16'd256);
        send_pixel(10'd5, 1'b1);
        send_pixel(10'd5, 1'b0);
        settle();
        write_reg(REG_FRAME_STEP, 16'd511);
        send_pixel(10'd6, 1'b1);
        send_pixel(10'd6, 1'b0);
        settle();
        write_reg(REG_HUE_SPREAD, 16'd1);
        send_pixel(10'd1023, 1'b0);
        settle();
        write_reg(REG_HUE_SPREAD, 16'd65535);
        send_pixel(10'd1023, 1'b1);

        for (int ph = 0; ph < 9; ph++)
        begin
            settle();
            gap_pct   = 20;
            stall_pct = 10;
            case (ph)
                0:
                begin
                    write_reg(REG_HUE_SPREAD, HUE_SPREAD_RESET);
                    write_reg(REG_FRAME_STEP, CFG_W'(FRAME_STEP_RESET));
                end
                1:
                begin
                    write_reg(REG_HUE_SPREAD, 16'd1);
                    write_reg(REG_FRAME_STEP, 16'd1);
                end
                2:
                begin
                    write_reg(REG_HUE_SPREAD, 16'd65535);
                    write_reg(REG_FRAME_STEP, 16'd256);
                end
                3:
                begin
                    // zero writes and spare indexes must leave 7 and 3 in place
                    write_reg(REG_HUE_SPREAD, 16'd7);
                    write_reg(REG_FRAME_STEP, 16'd3);
                    write_reg(REG_HUE_SPREAD, 16'd0);
                    write_reg(REG_FRAME_STEP, 16'hFE00);
                    write_reg(REG_SPARE_A, CFG_W'($urandom));
                    write_reg(REG_SPARE_B, CFG_W'($urandom));
                end
                4:
                begin
                    write_reg(REG_HUE_SPREAD, 16'd1024);
                    write_reg(REG_FRAME_STEP, 16'd511);
                    gap_pct   = 40;
                    stall_pct = 30;
                end
                5:
                begin
                    write_reg(REG_HUE_SPREAD, 16'd300);
                    write_reg(REG_FRAME_STEP, 16'd255);
                end
                6:
                begin
                    write_reg(REG_HUE_SPREAD, CFG_W'($urandom_range(1, 2048)));
                    write_reg(REG_FRAME_STEP, CFG_W'($urandom_range(1, 511)));
                end
                7:
                begin
                    write_reg(REG_HUE_SPREAD, CFG_W'($urandom_range(1, 65535)));
                    write_reg(REG_FRAME_STEP, CFG_W'($urandom_range(1, 511)));
                end
                default:
                begin
                    write_reg(REG_HUE_SPREAD, CFG_W'($urandom_range(2, 200)));
                    write_reg(REG_FRAME_STEP, CFG_W'($urandom_range(1, 64)));
                    gap_pct   = 0;
                    stall_pct = 0;
                end
            endcase
            run_frames(PHASE_ITEMS);
        end

        pix_in.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.report("missing beats", sb.pending(), 0);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/rcpg_pkg.sv
rtl/rcpg_if.sv
rtl/rcpg_div.sv
rtl/rainbow_cycle_pixel_generator.sv
tb/tb.sv
